>>> design/prefix_tree_word_store_top_defines.svh
// Assertion macros used by the prefix tree word store datapath.
`ifndef PREFIX_TREE_WORD_STORE_TOP_DEFINES_SVH
`define PREFIX_TREE_WORD_STORE_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define PTWS_ASSERT_HOLD(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("ptws: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define PTWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptws: implication violated");

`endif

>>> design/ptws_pkg.sv
// Package of the prefix tree word store: sizes, mode codes and shared types.
package ptws_pkg;

	localparam int NODES    = 1024;
	localparam int ALPHABET = 26;

	localparam int MODE_W   = 2;
	localparam int LETTER_W = 5;

	localparam int NODE_W      = $clog2(NODES);
	localparam int CNT_W       = $clog2(NODES + 1);
	localparam int ALPHA_IDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int ALPHA_CMP_W = $clog2(ALPHABET + 1);
	localparam int ALPHA_EXT_W = (LETTER_W > ALPHA_CMP_W) ? LETTER_W : ALPHA_CMP_W;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd2;

	typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [LETTER_W-1:0] letter;
		logic                first_of_word;
		logic                last_of_word;
		logic                empty_word;
	} item_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic lookup;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_empty;
		logic in_skip;
		logic in_last;
		logic item_last;
		logic out_free;
	} status_t;

endpackage

>>> design/ptws_in_if.sv
// Letter channel: one letter of a word per transaction.
interface ptws_in_if;
	logic                         valid;
	logic                         ready;
	logic [ptws_pkg::MODE_W-1:0]   mode;
	logic [ptws_pkg::LETTER_W-1:0] letter;
	logic                         first_of_word;
	logic                         last_of_word;
	logic                         empty_word;

	modport source (output valid, output mode, output letter, output first_of_word,
		output last_of_word, output empty_word, input ready);
	modport sink (input valid, input mode, input letter, input first_of_word,
		input last_of_word, input empty_word, output ready);
endinterface

>>> design/ptws_out_if.sv
// Result channel: one answer per completed word.
interface ptws_out_if;
	logic valid;
	logic ready;
	logic answer;
	logic table_full;

	modport source (output valid, output answer, output table_full, input ready);
	modport sink (input valid, input answer, input table_full, output ready);
endinterface

>>> design/ptws_ctrl.sv
// Controller of the prefix tree word store: clearing pass, letter walk and result hand-off.
module ptws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptws_pkg::status_t st,
	output ptws_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_MARK,
		S_RESULT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.in_empty)     state_d = S_MARK;
					else if (st.in_skip) state_d = st.in_last ? S_MARK : S_IDLE;
					else                 state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = st.item_last ? S_MARK : S_IDLE;
			end
			// wait here for the registered end-mark read of the final node
			S_MARK: state_d = S_RESULT;
			S_RESULT: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/ptws_dpath.sv
// Datapath of the prefix tree word store: child table, end marks, walk state and result register.
`include "prefix_tree_word_store_top_defines.svh"
module ptws_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  ptws_pkg::item_t   item,
	input  ptws_pkg::cmd_t    cmd,
	output ptws_pkg::status_t st,
	ptws_out_if.source        results
);

	localparam logic [ptws_pkg::CNT_W-1:0]  NODES_CNT = ptws_pkg::CNT_W'(ptws_pkg::NODES);
	localparam logic [ptws_pkg::NODE_W-1:0] LAST_NODE = ptws_pkg::NODE_W'(ptws_pkg::NODES - 1);
	localparam logic [ptws_pkg::ALPHA_EXT_W-1:0] ALPHA_LIM =
		ptws_pkg::ALPHA_EXT_W'(ptws_pkg::ALPHABET);

	// memories
	ptws_pkg::row_t row_mem [ptws_pkg::NODES];
	logic           mark_mem [ptws_pkg::NODES];

	ptws_pkg::row_t row_rd_q;
	logic           mark_rd_q;

	// walk state
	logic [ptws_pkg::NODE_W-1:0]      node_q;
	logic [ptws_pkg::CNT_W-1:0]       nodes_in_use_q;
	logic                             missing_q;
	logic                             over_q;
	logic [ptws_pkg::NODE_W-1:0]      clr_addr_q;
	logic [ptws_pkg::MODE_W-1:0]      mode_q;
	logic [ptws_pkg::ALPHA_EXT_W-1:0] letter_q;
	logic                             last_q;

	logic out_valid_q;
	logic answer_q;
	logic full_q;

	// accept-time view
	logic [ptws_pkg::ALPHA_EXT_W-1:0] letter_ext;
	logic                             bad_letter;
	logic                             eff_missing;
	logic                             eff_over;
	logic [ptws_pkg::NODE_W-1:0]      eff_node;
	logic                             row_re;

	// lookup-time view
	logic [ptws_pkg::NODE_W-1:0] link;
	logic                        room;
	logic                        alloc;
	ptws_pkg::row_t              row_upd;

	logic                        row_we;
	logic [ptws_pkg::NODE_W-1:0] row_waddr;
	ptws_pkg::row_t              row_wdata;
	logic                        mark_we;
	logic [ptws_pkg::NODE_W-1:0] mark_waddr;
	logic                        mark_wdata;

	logic answer_d;
	logic full_d;
	logic [ptws_pkg::CNT_W-1:0] node_ext;

	assign letter_ext  = ptws_pkg::ALPHA_EXT_W'(item.letter);
	assign bad_letter  = (letter_ext >= ALPHA_LIM);
	assign eff_missing = item.first_of_word ? 1'b0 : missing_q;
	assign eff_over    = item.first_of_word ? 1'b0 : over_q;
	assign eff_node    = item.first_of_word ? '0 : node_q;
	assign row_re      = cmd.accept && !item.empty_word && !st.in_skip;

	assign link    = row_rd_q[letter_q[ptws_pkg::ALPHA_IDX_W-1:0]];
	assign room    = (nodes_in_use_q < NODES_CNT);
	assign alloc   = cmd.lookup && (link == '0) && (mode_q == ptws_pkg::MODE_INSERT) && room;

	always_comb begin
		row_upd = row_rd_q;
		row_upd[letter_q[ptws_pkg::ALPHA_IDX_W-1:0]] = nodes_in_use_q[ptws_pkg::NODE_W-1:0];
	end

	// one write port each, shared by the clearing sweep and the walk
	assign row_we     = cmd.clr_step || alloc;
	assign row_waddr  = cmd.clr_step ? clr_addr_q : node_q;
	assign row_wdata  = cmd.clr_step ? '0 : row_upd;
	assign mark_we    = cmd.clr_step ||
		(cmd.finish && (mode_q == ptws_pkg::MODE_INSERT) && !over_q && !missing_q);
	assign mark_waddr = cmd.clr_step ? clr_addr_q : node_q;
	assign mark_wdata = !cmd.clr_step;

	always_comb begin
		answer_d = 1'b0;
		full_d   = 1'b0;
		case (mode_q)
			ptws_pkg::MODE_INSERT: begin
				full_d   = over_q;
				answer_d = !over_q && !missing_q;
			end
			ptws_pkg::MODE_SEARCH: answer_d = !over_q && !missing_q && mark_rd_q;
			ptws_pkg::MODE_PREFIX: answer_d = !over_q && !missing_q;
			// mode three walks and answers as a prefix test
			default:               answer_d = !over_q && !missing_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_waddr] <= row_wdata;
		if (row_re) row_rd_q <= row_mem[eff_node];
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
		mark_rd_q <= mark_mem[node_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= item.mode;
			letter_q <= letter_ext;
			last_q   <= item.last_of_word;
		end
		if (cmd.finish) begin
			answer_q <= answer_d;
			full_q   <= full_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q         <= '0;
			nodes_in_use_q <= ptws_pkg::CNT_W'(1);
			missing_q      <= 1'b0;
			over_q         <= 1'b0;
			clr_addr_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + ptws_pkg::NODE_W'(1);

			if (cmd.accept) begin
				if (item.empty_word) begin
					node_q    <= '0;
					missing_q <= 1'b0;
					over_q    <= 1'b0;
				end else begin
					node_q    <= eff_node;
					over_q    <= eff_over;
					missing_q <= eff_missing || (!eff_over && bad_letter);
				end
			end

			if (cmd.lookup) begin
				if (link != '0) begin
					node_q <= link;
				end else if (mode_q != ptws_pkg::MODE_INSERT) begin
					missing_q <= 1'b1;
				end else if (room) begin
					node_q         <= nodes_in_use_q[ptws_pkg::NODE_W-1:0];
					nodes_in_use_q <= nodes_in_use_q + ptws_pkg::CNT_W'(1);
				end else begin
					over_q <= 1'b1;
				end
			end

			// return the walk to the root once the answer is loaded into the result register
			if (cmd.finish) begin
				node_q      <= '0;
				missing_q   <= 1'b0;
				over_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid      = out_valid_q;
	assign results.answer     = answer_q;
	assign results.table_full = full_q;

	always_comb begin
		st           = '0;
		st.clr_last  = (clr_addr_q == LAST_NODE);
		st.in_empty  = item.empty_word;
		st.in_skip   = eff_missing || eff_over || bad_letter;
		st.in_last   = item.last_of_word;
		st.item_last = last_q;
		st.out_free  = !out_valid_q || results.ready;
	end

	assign node_ext = ptws_pkg::CNT_W'(node_q);

	`PTWS_ASSERT_HOLD(a_pool_bounds, clk, arst_n, (nodes_in_use_q != '0) && (nodes_in_use_q <= NODES_CNT))
	`PTWS_ASSERT_HOLD(a_node_allocated, clk, arst_n, node_ext < nodes_in_use_q)
	`PTWS_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.finish, !out_valid_q || results.ready)

endmodule

>>> design/prefix_tree_word_store_top.sv
// Top level of the prefix tree word store: controller, datapath and channel wiring.
//
// Usage: words arrive on the letters channel, one letter per transaction, with
// mode (insert, exact search, prefix test), first_of_word, last_of_word and
// empty_word. A transaction that closes a word (last_of_word or empty_word)
// yields one transaction on the results channel carrying answer and table_full.
// Timing: a letter that reads the child table passes through accept, then the
// registered row read and update; a letter skipped after a miss needs only the
// accept. A word's closing letter then adds the end-mark read and the result
// load before its result is valid. The child table read-modify-write holds off
// the next letter until the row update is done.
// Reset: after arst_n is released the block sweeps the child table and the end
// marks, one node row per cycle, for NODES (1024) cycles with ready low.
// Stall: a result waits in the output register; further letters are still
// accepted until the next word is complete, which then holds in its result
// state, with ready low, until the output register is free.
module prefix_tree_word_store_top (
	input  logic       clk,
	input  logic       arst_n,
	ptws_in_if.sink    letters,
	ptws_out_if.source results
);

	ptws_pkg::item_t   item;
	ptws_pkg::cmd_t    cmd;
	ptws_pkg::status_t st;
	logic              in_ready;

	assign item.mode          = letters.mode;
	assign item.letter        = letters.letter;
	assign item.first_of_word = letters.first_of_word;
	assign item.last_of_word  = letters.last_of_word;
	assign item.empty_word    = letters.empty_word;
	assign letters.ready      = in_ready;

	ptws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (letters.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ptws_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.st      (st),
		.results (results)
	);

endmodule

>>> verif/tb_prefix_tree_word_store_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the prefix tree word store: directed and random words against a tree predictor.
module tb_prefix_tree_word_store_top;

	localparam logic [ptws_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;  // decodes as a prefix test
	localparam int IDLE_LIMIT   = 6000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 570;

	typedef struct packed {
		logic answer;
		logic table_full;
	} answer_t;

	logic clk;
	logic arst_n = 1'b0;

	ptws_in_if  letters ();
	ptws_out_if results ();

	prefix_tree_word_store_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.letters (letters),
		.results (results)
	);

	// Stimulus side
	logic            in_valid  = 1'b0;
	ptws_pkg::item_t in_item   = '0;
	logic            res_ready = 1'b0;
	bit              in_fire   = 1'b0;
	bit              out_fire  = 1'b0;
	int              send_gap  = 0;
	int              take_gap  = 0;
	int              hold_left = 0;
	bit              hold_done = 1'b0;
	int              letters_taken = 0;
	int              cyc = 0;
	int              idle_cycles = 0;
	int              errors = 0;

	assign letters.valid         = in_valid;
	assign letters.mode          = in_item.mode;
	assign letters.letter        = in_item.letter;
	assign letters.first_of_word = in_item.first_of_word;
	assign letters.last_of_word  = in_item.last_of_word;
	assign letters.empty_word    = in_item.empty_word;
	assign results.ready         = res_ready;

	ptws_pkg::item_t letters_pending [$];
	answer_t         pending_answers [$];
	string           stored_words [$];

	// Tree predictor state
	logic [ptws_pkg::NODE_W-1:0] tree_links [ptws_pkg::NODES*ptws_pkg::ALPHABET];
	bit                          tree_marks [ptws_pkg::NODES];
	int unsigned                 tree_used;
	logic [ptws_pkg::NODE_W-1:0] walk_node;
	bit                          walk_missing;
	bit                          walk_overflow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic restart_walk();
		walk_node     = '0;
		walk_missing  = 1'b0;
		walk_overflow = 1'b0;
	endtask

	task automatic walk_step(logic [ptws_pkg::MODE_W-1:0] m, logic [ptws_pkg::LETTER_W-1:0] l);
		int unsigned slot;
		if (walk_missing || walk_overflow)
			return;
		if (int'(l) >= ptws_pkg::ALPHABET) begin
			walk_missing = 1'b1;
			return;
		end
		slot = int'(walk_node) * ptws_pkg::ALPHABET + int'(l);
		if (tree_links[slot] != '0) begin
			walk_node = tree_links[slot];
		end else if (m != ptws_pkg::MODE_INSERT) begin
			walk_missing = 1'b1;
		end else if (tree_used < ptws_pkg::NODES) begin
			tree_links[slot] = ptws_pkg::NODE_W'(tree_used);
			walk_node = ptws_pkg::NODE_W'(tree_used);
			tree_used++;
		end else begin
			walk_overflow = 1'b1;
		end
	endtask

	task automatic close_word(logic [ptws_pkg::MODE_W-1:0] m);
		answer_t r;
		r = '0;
		if (m == ptws_pkg::MODE_INSERT) begin
			if (walk_overflow) begin
				r.table_full = 1'b1;
			end else if (!walk_missing) begin
				tree_marks[walk_node] = 1'b1;
				r.answer = 1'b1;
			end
		end else if (m == ptws_pkg::MODE_SEARCH) begin
			r.answer = !walk_missing && !walk_overflow && tree_marks[walk_node];
		end else begin
			r.answer = !walk_missing && !walk_overflow;
		end
		pending_answers = {pending_answers, r};
		restart_walk();
	endtask

	task automatic trie_apply(ptws_pkg::item_t it);
		logic [ptws_pkg::MODE_W-1:0] m;
		m = (it.mode == MODE_SPARE) ? ptws_pkg::MODE_PREFIX : it.mode;
		if (it.empty_word) begin
			restart_walk();
			close_word(m);
		end else begin
			if (it.first_of_word)
				restart_walk();
			walk_step(m, it.letter);
			if (it.last_of_word)
				close_word(m);
		end
	endtask

	// Quiet stretches: no idling on either side
	function automatic int pick_gap();
		if ((cyc / 256) % 4 == 1)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	task automatic queue_item(logic [ptws_pkg::MODE_W-1:0] m, logic [ptws_pkg::LETTER_W-1:0] l,
		bit f, bit la, bit e);
		ptws_pkg::item_t it;
		it.mode          = m;
		it.letter        = l;
		it.first_of_word = f;
		it.last_of_word  = la;
		it.empty_word    = e;
		letters_pending = {letters_pending, it};
	endtask

	task automatic queue_word(logic [ptws_pkg::MODE_W-1:0] m, string w, bit mixed);
		logic [ptws_pkg::MODE_W-1:0] lm;
		for (int i = 0; i < w.len(); i++) begin
			lm = (mixed && i < w.len() - 1) ? ptws_pkg::MODE_W'($urandom_range(0, 3)) : m;
			queue_item(lm, ptws_pkg::LETTER_W'(w[i] - 8'd97), i == 0, i == w.len() - 1, 1'b0);
		end
	endtask

	function automatic string rand_word(int len, int top);
		string s;
		s = "";
		for (int i = 0; i < len; i++)
			s = $sformatf("%s%c", s, 8'd97 + 8'($urandom_range(0, top)));
		return s;
	endfunction

	function automatic string known_word();
		if (stored_words.size() == 0)
			return rand_word(2, 3);
		return stored_words[$urandom_range(0, stored_words.size() - 1)];
	endfunction

	task automatic queue_random_word();
		int    kind;
		int    n;
		bit    mixed;
		string w;
		kind  = $urandom_range(0, 99);
		mixed = ($urandom_range(0, 9) == 0);
		if (kind < 30) begin
			w = rand_word($urandom_range(1, 6), $urandom_range(0, 1) ? 3 : 25);
			queue_word(ptws_pkg::MODE_INSERT, w, mixed);
			if (stored_words.size() < 256)
				stored_words = {stored_words, w};
		end else if (kind < 55) begin
			w = ($urandom_range(0, 9) < 7) ? known_word() : rand_word($urandom_range(1, 5), 3);
			if ($urandom_range(0, 4) == 0)
				w = {w, rand_word(1, 3)};
			queue_word(ptws_pkg::MODE_SEARCH, w, mixed);
		end else if (kind < 70) begin
			w = known_word();
			w = w.substr(0, $urandom_range(0, w.len() - 1));
			queue_word(($urandom_range(0, 3) == 0) ? MODE_SPARE : ptws_pkg::MODE_PREFIX, w, mixed);
		end else if (kind < 78) begin
			queue_item(ptws_pkg::MODE_W'($urandom_range(0, 3)),
				ptws_pkg::LETTER_W'($urandom_range(0, 31)),
				bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), 1'b1);
		end else if (kind < 90) begin
			// Broken word: may lack its first mark, may carry letters beyond z
			w = rand_word($urandom_range(1, 5), 25);
			n = w.len();
			for (int i = 0; i < n; i++)
				queue_item(ptws_pkg::MODE_W'($urandom_range(0, 3)),
					($urandom_range(0, 3) == 0)
						? ptws_pkg::LETTER_W'($urandom_range(ptws_pkg::ALPHABET, 31))
						: ptws_pkg::LETTER_W'(w[i] - 8'd97),
					(i == 0) && bit'($urandom_range(0, 1)), i == n - 1, 1'b0);
		end else begin
			queue_item(ptws_pkg::MODE_W'($urandom_range(0, 3)),
				ptws_pkg::LETTER_W'($urandom_range(0, 31)),
				bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), 1'b0);
		end
	endtask

	// Letters driver: advance after each transaction, then idle for the drawn gap
	always @(negedge clk) begin : drive_letters
		logic            nv;
		ptws_pkg::item_t ni;
		int              g;
		nv = in_valid;
		ni = in_item;
		g  = send_gap;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!in_valid || in_fire) begin
			if (in_fire)
				g = pick_gap();
			if (g > 0) begin
				nv = 1'b0;
				g--;
			end else if (letters_pending.size() > 0) begin
				ni = letters_pending.pop_front();
				nv = 1'b1;
			end else begin
				nv = 1'b0;
			end
		end
		in_valid <= nv;
		in_item  <= ni;
		send_gap <= g;
	end

	// Long hold-off on the results side, once, so the block backs up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && letters_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk) begin : drive_ready
		int w;
		w = take_gap;
		if (out_fire)
			w = pick_gap();
		else if (w > 0)
			w--;
		take_gap  <= w;
		res_ready <= arst_n && (w == 0) && (hold_left == 0);
	end

	always @(posedge clk) begin : observe
		answer_t seen;
		answer_t want;
		bit      took_in;
		bit      took_out;
		took_in  = arst_n && in_valid && letters.ready;
		took_out = arst_n && results.valid && res_ready;
		cyc      <= cyc + 1;
		in_fire  <= took_in;
		out_fire <= took_out;
		if (took_in) begin
			trie_apply(in_item);
			letters_taken <= letters_taken + 1;
		end
		if (took_out) begin
			seen.answer     = results.answer;
			seen.table_full = results.table_full;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result: answer %0b table_full %0b", $time,
					seen.answer, seen.table_full);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (seen.answer !== want.answer) begin
					$display("%0t: answer expected %0b actual %0b", $time,
						want.answer, seen.answer);
					errors++;
				end
				if (seen.table_full !== want.table_full) begin
					$display("%0t: table_full expected %0b actual %0b", $time,
						want.table_full, seen.table_full);
					errors++;
				end
			end
		end
		if (took_in || took_out)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("prefix_tree_word_store_top regression: fail");
			$finish;
		end
	end

	initial begin
		int base;
		for (int i = 0; i < ptws_pkg::NODES * ptws_pkg::ALPHABET; i++)
			tree_links[i] = '0;
		for (int i = 0; i < ptws_pkg::NODES; i++)
			tree_marks[i] = 1'b0;
		tree_used = 1;
		restart_walk();

		// Empty words on an empty tree, then a marked root
		queue_item(ptws_pkg::MODE_SEARCH, 5'd0, 1'b1, 1'b1, 1'b1);
		queue_item(ptws_pkg::MODE_PREFIX, 5'd0, 1'b0, 1'b0, 1'b1);
		queue_item(ptws_pkg::MODE_INSERT, 5'd31, 1'b0, 1'b1, 1'b1);
		queue_item(ptws_pkg::MODE_SEARCH, 5'd17, 1'b1, 1'b0, 1'b1);
		queue_word(ptws_pkg::MODE_INSERT, "a", 1'b0);
		queue_word(ptws_pkg::MODE_INSERT, "zz", 1'b0);
		queue_word(ptws_pkg::MODE_SEARCH, "zz", 1'b0);
		queue_word(ptws_pkg::MODE_SEARCH, "z", 1'b0);
		queue_word(MODE_SPARE, "z", 1'b0);
		queue_word(ptws_pkg::MODE_SEARCH, "b", 1'b0);
		// Letters beyond z stop the walk
		queue_item(ptws_pkg::MODE_PREFIX, 5'd31, 1'b1, 1'b1, 1'b0);
		queue_item(ptws_pkg::MODE_INSERT, 5'd26, 1'b1, 1'b1, 1'b0);
		// Mode taken per letter: walk in search mode, insert on the last
		queue_item(ptws_pkg::MODE_SEARCH, 5'd0, 1'b1, 1'b0, 1'b0);
		queue_item(ptws_pkg::MODE_INSERT, 5'd1, 1'b0, 1'b1, 1'b0);
		queue_word(ptws_pkg::MODE_SEARCH, "ab", 1'b0);
		// No first mark: carry on from the root after a result
		queue_item(ptws_pkg::MODE_SEARCH, 5'd0, 1'b0, 1'b1, 1'b0);
		queue_word(ptws_pkg::MODE_SEARCH, "qx", 1'b0);
		queue_item(ptws_pkg::MODE_INSERT, 5'd2, 1'b1, 1'b0, 1'b0);
		queue_item(ptws_pkg::MODE_INSERT, 5'd30, 1'b0, 1'b0, 1'b0);
		queue_item(ptws_pkg::MODE_INSERT, 5'd3, 1'b0, 1'b1, 1'b0);
		queue_word(ptws_pkg::MODE_SEARCH, "c", 1'b0);
		queue_word(ptws_pkg::MODE_PREFIX, "c", 1'b0);
		stored_words = {stored_words, "a", "zz", "ab"};

		base = letters_pending.size();
		while (letters_pending.size() < base + RANDOM_ITEMS)
			queue_random_word();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(letters_pending.size() == 0 && !in_valid))
			@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_answers.size());
			errors++;
		end
		if (errors == 0)
			$display("prefix_tree_word_store_top regression: pass");
		else
			$display("prefix_tree_word_store_top regression: fail");
		$finish;
	end

endmodule
